>>> sv/ptq_pkg.sv
package ptq_pkg;

	localparam int PTQ_DEPTH = 16;

	localparam int OP_W = 2;
	localparam int ID_W = 16;
	localparam int PRI_W = 8;
	localparam int ST_W = 2;
	localparam int OCC_W = 5;

	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_POP = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] task_id;
		logic [PRI_W-1:0] task_priority;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [ID_W-1:0] removed_id;
		logic [PRI_W-1:0] removed_priority;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [PRI_W-1:0] prio;
	} entry_t;

endpackage

>>> sv/ptq_ram.sv
module ptq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/priority_task_queue.sv
// Channel   Handshake          Payload  Direction
// request   start, busy        request  in
// result    done (strobe)      result   out
//
// An unused op code, an add to a full or empty list and a pop or remove on an
// empty list are answered in the cycle after the request with busy never raised.
// Any other add scans the entry memory from the tail, one entry a cycle, until
// it finds an entry of equal or higher priority or reaches the head; a pop or
// remove scans from the head to the tail. The entry memory has a single read
// port. Reset clears the count and the control registers but not the entry
// memory, so the block takes a request in the first cycle after reset. The
// result is flagged by done for one cycle and cannot be stalled.
module priority_task_queue import ptq_pkg::*; #(
	parameter int DEPTH = PTQ_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input req_t request,
	output logic done,
	output rsp_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADD = 2'd1;
	localparam logic [1:0] S_HEAD = 2'd2;
	localparam logic [1:0] S_DEL = 2'd3;

	logic [1:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] last_q;
	logic found_q;
	logic [OP_W-1:0] op_q;
	logic [ID_W-1:0] id_q;
	logic [PRI_W-1:0] pri_q;
	logic [ID_W-1:0] rid_q;
	logic [PRI_W-1:0] rpri_q;
	logic done_q;
	rsp_t result_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	entry_t ram_wdata;
	entry_t ram_rdata;

	logic accept;
	logic hit;
	logic [AW-1:0] tail_idx;
	entry_t new_entry;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign tail_idx = AW'(cnt_q - CW'(1));
	assign new_entry = '{id: id_q, prio: pri_q};
	assign hit = !found_q && ((op_q == OP_POP) || (ram_rdata.id == id_q));
	assign done = done_q;
	assign result = result_q;

	ptq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The scans write one slot behind the entry they examine, so a slot is never
	// written before the scan has read it and no forwarding is needed.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && request.op == OP_ADD) begin
					ram_raddr = tail_idx;
					if (cnt_q == '0) begin
						ram_we = 1'b1;
						ram_wdata = '{id: request.task_id, prio: request.task_priority};
					end
				end
			end
			S_ADD: begin
				ram_we = 1'b1;
				ram_waddr = idx_q + AW'(1);
				if (ram_rdata.prio >= pri_q) begin
					ram_wdata = new_entry;
				end else begin
					ram_raddr = idx_q - AW'(1);
				end
			end
			S_HEAD: begin
				ram_we = 1'b1;
				ram_wdata = new_entry;
			end
			S_DEL: begin
				ram_we = found_q;
				ram_waddr = idx_q - AW'(1);
				if (idx_q != last_q) begin
					ram_raddr = idx_q + AW'(1);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
			rid_q <= '0;
			rpri_q <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (request.op == OP_ADD) begin
							idx_q <= tail_idx;
						end else begin
							idx_q <= '0;
						end
						result_q.status <= ST_OK;
						result_q.removed_id <= '0;
						result_q.removed_priority <= '0;
						result_q.occupancy <= OCC_W'(cnt_q);
						case (request.op)
							OP_ADD: begin
								if (cnt_q == CW'(DEPTH)) begin
									result_q.status <= ST_FULL;
									done_q <= 1'b1;
								end else if (cnt_q == '0) begin
									cnt_q <= CW'(1);
									result_q.occupancy <= OCC_W'(1);
									done_q <= 1'b1;
								end else begin
									state_q <= S_ADD;
								end
							end
							OP_POP, OP_REMOVE: begin
								if (cnt_q == '0) begin
									result_q.status <= ST_EMPTY;
									done_q <= 1'b1;
								end else begin
									state_q <= S_DEL;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_ADD: begin
					if (ram_rdata.prio >= pri_q) begin
						cnt_q <= cnt_q + CW'(1);
						result_q.occupancy <= OCC_W'(cnt_q + CW'(1));
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (idx_q == '0) begin
						state_q <= S_HEAD;
					end else begin
						idx_q <= idx_q - AW'(1);
					end
				end
				S_HEAD: begin
					cnt_q <= cnt_q + CW'(1);
					result_q.occupancy <= OCC_W'(cnt_q + CW'(1));
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DEL: begin
					if (hit) begin
						found_q <= 1'b1;
						rid_q <= ram_rdata.id;
						rpri_q <= ram_rdata.prio;
					end
					if (idx_q == last_q) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
						if (found_q || hit) begin
							cnt_q <= cnt_q - CW'(1);
							result_q.occupancy <= OCC_W'(cnt_q - CW'(1));
							result_q.removed_id <= found_q ? rid_q : ram_rdata.id;
							result_q.removed_priority <= found_q ? rpri_q : ram_rdata.prio;
						end else begin
							result_q.status <= ST_NOT_FOUND;
						end
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= request.op;
			id_q <= request.task_id;
			pri_q <= request.task_priority;
			last_q <= tail_idx;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count exceeds capacity");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> cnt_q != '0)
		else $error("scan running over an empty list");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without a request in progress");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_EMPTY |-> result.occupancy == '0 && cnt_q == '0)
		else $error("empty status with entries held");
`endif

endmodule
